>>> hdl/tlaid_pkg.sv
// ----------------------------------------------------------------------------
// tlaid_pkg
// Types, register codes and constants of the two-link arm inverse dynamics
// core.
// ----------------------------------------------------------------------------
package tlaid_pkg;

   typedef logic signed [63:0] word_type;

   typedef enum logic [2:0] {
      CSR_LINK1_LENGTH   = 3'd0,
      CSR_LINK1_COM_DIST = 3'd1,
      CSR_LINK2_COM_DIST = 3'd2,
      CSR_LINK1_MASS     = 3'd3,
      CSR_LINK2_MASS     = 3'd4,
      CSR_LINK1_INERTIA  = 3'd5,
      CSR_LINK2_INERTIA  = 3'd6,
      CSR_GRAVITY_ACCEL  = 3'd7
   } csr_index_type;

   localparam int NUM_CSR = 8;

   localparam logic [31:0] CSR_RESET [NUM_CSR] = '{
      32'd5830083, 32'd2914202, 32'd2795084, 32'd15099494,
      32'd15099494, 32'd1678, 32'd1678, 32'd164584489
   };

   typedef struct packed {
      logic signed [15:0] shoulder_angle;
      logic signed [15:0] elbow_angle;
      logic signed [23:0] shoulder_velocity;
      logic signed [23:0] elbow_velocity;
      logic signed [23:0] shoulder_accel;
      logic signed [23:0] elbow_accel;
   } req_type;

   typedef struct packed {
      logic signed [31:0] shoulder_torque;
      logic signed [31:0] elbow_torque;
      logic               saturated;
   } rsp_type;

   // one Horner step's working set
   typedef struct packed {
      logic [31:0] x;
      logic [31:0] x2;
      logic [30:0] t;
      logic        neg;
   } horner_type;

   localparam logic [31:0] PI_Q30       = 32'd3373259426;
   localparam logic [30:0] ONE_Q30      = 31'h4000_0000;
   localparam logic [15:0] QUARTER_TURN = 16'd16384;
   localparam logic [59:0] SAT_LIM      = 60'h800_0000_0000_0000;
   localparam int          HORNER_STEPS = 5;

   function automatic logic [6:0] horner_div(input int step);
      logic [6:0] d;
      case (step)
         0:       d = 7'd110;
         1:       d = 7'd72;
         2:       d = 7'd42;
         3:       d = 7'd20;
         default: d = 7'd6;
      endcase
      return d;
   endfunction

   // floor(2^34 / divisor)
   function automatic logic [31:0] horner_recip(input int step);
      logic [31:0] m;
      case (step)
         0:       m = 32'd156180628;
         1:       m = 32'd238609294;
         2:       m = 32'd409044504;
         3:       m = 32'd858993459;
         default: m = 32'd2863311530;
      endcase
      return m;
   endfunction

   function automatic word_type q12_to_q24(input logic signed [23:0] v);
      return {{28{v[23]}}, v, 12'b0};
   endfunction

endpackage

>>> hdl/tlaid_mul_cell.sv
// ----------------------------------------------------------------------------
// tlaid_mul_cell
// Five-stage signed fixed-point multiply: magnitude product from four 32x32
// partial products, shifted right by SH, magnitude clamped at 2^59.
// ----------------------------------------------------------------------------
module tlaid_mul_cell #(
   parameter int SH = 24
) (
   input  logic               clock,
   input  logic               en,
   input  tlaid_pkg::word_type op_a,
   input  tlaid_pkg::word_type op_b,
   output tlaid_pkg::word_type prod
);

   localparam int QW = 128 - SH;

   logic [63:0]         ma_ff, mb_ff, ma_in, mb_in;
   logic                neg1_ff, neg2_ff, neg3_ff, neg4_ff;
   logic [63:0]         pp0_ff, pp1_ff, pp2_ff, pp3_ff;
   logic [64:0]         mid_ff;
   logic [63:0]         lo_ff, hi_ff;
   logic [127:0]        full_ff;
   logic [QW-1:0]       q;
   logic [59:0]         mag;
   tlaid_pkg::word_type prod_ff, prod_in;

   assign ma_in = op_a[63] ? (~op_a + 64'd1) : op_a;
   assign mb_in = op_b[63] ? (~op_b + 64'd1) : op_b;

   assign q       = full_ff[127:SH];
   assign mag     = (q > QW'(tlaid_pkg::SAT_LIM)) ? tlaid_pkg::SAT_LIM : q[59:0];
   assign prod_in = neg4_ff ? -$signed({4'b0, mag}) : $signed({4'b0, mag});

   always_ff @(posedge clock) begin
      if (en) begin
         ma_ff   <= ma_in;
         mb_ff   <= mb_in;
         neg1_ff <= op_a[63] ^ op_b[63];
         pp0_ff  <= ma_ff[31:0]  * mb_ff[31:0];
         pp1_ff  <= ma_ff[31:0]  * mb_ff[63:32];
         pp2_ff  <= ma_ff[63:32] * mb_ff[31:0];
         pp3_ff  <= ma_ff[63:32] * mb_ff[63:32];
         neg2_ff <= neg1_ff;
         mid_ff  <= {1'b0, pp1_ff} + {1'b0, pp2_ff};
         lo_ff   <= pp0_ff;
         hi_ff   <= pp3_ff;
         neg3_ff <= neg2_ff;
         full_ff <= {64'b0, lo_ff} + {31'b0, mid_ff, 32'b0} + {hi_ff, 64'b0};
         neg4_ff <= neg3_ff;
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

>>> hdl/tlaid_horner_cell.sv
// ----------------------------------------------------------------------------
// tlaid_horner_cell
// One three-stage Horner step of the sine polynomial:
// t <- 1 - ((x2 * t) >> 30) / divisor, divisor by reciprocal and correction.
// ----------------------------------------------------------------------------
module tlaid_horner_cell #(
   parameter int STEP = 0
) (
   input  logic                  clock,
   input  logic                  en,
   input  tlaid_pkg::horner_type cell_in,
   output tlaid_pkg::horner_type cell_out
);

   localparam logic [6:0]  DIV   = tlaid_pkg::horner_div(STEP);
   localparam logic [31:0] RECIP = tlaid_pkg::horner_recip(STEP);

   logic [62:0]           prod_ff;
   tlaid_pkg::horner_type h1_ff, h2_ff, out_ff, out_in;
   logic [31:0]           n;
   logic [31:0]           n_ff;
   logic [63:0]           qm_ff;
   logic [29:0]           q0;
   logic [31:0]           rem;
   logic [30:0]           p;

   assign n   = prod_ff[61:30];
   assign q0  = qm_ff[63:34];
   assign rem = n_ff - 32'({2'b0, q0} * DIV);
   assign p   = (rem >= 32'(DIV)) ? ({1'b0, q0} + 31'd1) : {1'b0, q0};

   always_comb begin
      out_in   = h2_ff;
      out_in.t = (p >= tlaid_pkg::ONE_Q30) ? '0 : (tlaid_pkg::ONE_Q30 - p);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= cell_in.x2 * cell_in.t;
         h1_ff   <= cell_in;
         qm_ff   <= n * RECIP;
         n_ff    <= n;
         h2_ff   <= h1_ff;
         out_ff  <= out_in;
      end
   end

   assign cell_out = out_ff;

endmodule

>>> hdl/tlaid_sin_unit.sv
// ----------------------------------------------------------------------------
// tlaid_sin_unit
// Twenty-stage sine of a binary angle in Q2.30: quadrant fold, scaling by pi,
// a chain of five Horner cells and the final multiply by x.
// ----------------------------------------------------------------------------
module tlaid_sin_unit (
   input  logic               clock,
   input  logic               en,
   input  logic [15:0]        angle,
   output logic signed [31:0] sine
);

   logic [14:0]           r_ff, r_in;
   logic                  neg1_ff, neg2_ff, sneg_ff;
   logic [46:0]           xp;
   logic [31:0]           x_ff;
   logic [63:0]           sq;
   tlaid_pkg::horner_type h0_ff, h0_in;
   tlaid_pkg::horner_type chain [0:tlaid_pkg::HORNER_STEPS];
   logic [62:0]           sp;
   logic [31:0]           s_ff;
   logic signed [31:0]    sine_ff;

   assign r_in = angle[14] ? (15'd16384 - {1'b0, angle[13:0]}) : {1'b0, angle[13:0]};
   assign xp   = r_ff * tlaid_pkg::PI_Q30;
   assign sq   = x_ff * x_ff;

   always_comb begin
      h0_in.x   = x_ff;
      h0_in.x2  = sq[61:30];
      h0_in.t   = tlaid_pkg::ONE_Q30;
      h0_in.neg = neg2_ff;
   end

   assign chain[0] = h0_ff;

   for (genvar k = 0; k < tlaid_pkg::HORNER_STEPS; k++) begin : g_horner
      tlaid_horner_cell #(.STEP(k)) u_cell (
         .clock    (clock),
         .en       (en),
         .cell_in  (chain[k]),
         .cell_out (chain[k+1])
      );
   end

   assign sp = chain[tlaid_pkg::HORNER_STEPS].x * chain[tlaid_pkg::HORNER_STEPS].t;

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff    <= r_in;
         neg1_ff <= angle[15];
         x_ff    <= xp[46:15];
         neg2_ff <= neg1_ff;
         h0_ff   <= h0_in;
         s_ff    <= sp[61:30];
         sneg_ff <= chain[tlaid_pkg::HORNER_STEPS].neg;
         sine_ff <= sneg_ff ? -$signed(s_ff) : $signed(s_ff);
      end
   end

   assign sine = sine_ff;

endmodule

>>> hdl/two_link_arm_inverse_dynamics_core.sv
// ----------------------------------------------------------------------------
// two_link_arm_inverse_dynamics_core
// Joint torques of a planar two-link arm (inertia, Coriolis/centrifugal and
// gravity terms) in fixed point, as a row of pipelined multiply and sine cells.
// ----------------------------------------------------------------------------
//  Channel  Ports                          Direction  Contents
//  req      req_valid/req_ready/req_data   in         angles, rates, accels
//  rsp      rsp_valid/rsp_ready/rsp_data   out        torques, saturated flag
//  csr      csr_wr_en/csr_index/csr_wr_data in        link constants
//
// One item per cycle while the row is not stalled; an item's result passes
// the sine cells, three multiply cells in series, two alignment registers,
// two sum stages, a magnitude stage and the output register.
// Register-only products run free and settle after a csr write, before any
// item accepted after the write reaches them. Reset clears the valids and
// loads the csr reset values.
// The row stalls only when its last stage and the output register are both
// full and rsp_ready is low.
// ----------------------------------------------------------------------------
module two_link_arm_inverse_dynamics_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  tlaid_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output tlaid_pkg::rsp_type rsp_data,
   input  logic               csr_wr_en,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wr_data
);

   localparam int LAST = 40;

   typedef tlaid_pkg::word_type word_type;

   logic [31:0]        csr_ff [tlaid_pkg::NUM_CSR];
   logic               adv;
   logic [LAST:0]      v_ff;
   tlaid_pkg::req_type req_d_ff [0:32];
   logic               rsp_valid_ff;
   tlaid_pkg::rsp_type rsp_ff, rsp_in;

   word_type l1, lc1, lc2, m1, m2, i1, i2, g;
   assign l1  = $signed({32'b0, csr_ff[tlaid_pkg::CSR_LINK1_LENGTH]});
   assign lc1 = $signed({32'b0, csr_ff[tlaid_pkg::CSR_LINK1_COM_DIST]});
   assign lc2 = $signed({32'b0, csr_ff[tlaid_pkg::CSR_LINK2_COM_DIST]});
   assign m1  = $signed({32'b0, csr_ff[tlaid_pkg::CSR_LINK1_MASS]});
   assign m2  = $signed({32'b0, csr_ff[tlaid_pkg::CSR_LINK2_MASS]});
   assign i1  = $signed({32'b0, csr_ff[tlaid_pkg::CSR_LINK1_INERTIA]});
   assign i2  = $signed({32'b0, csr_ff[tlaid_pkg::CSR_LINK2_INERTIA]});
   assign g   = $signed({32'b0, csr_ff[tlaid_pkg::CSR_GRAVITY_ACCEL]});

   // register-only products, free running
   word_type l1l2, lc2sq, lc1sq, l1sq, gm2, glc1, glc2;
   word_type l1l2m2, m1lc1sq, m2lc2sq, glc1m1, glc2m2, d22;

   tlaid_mul_cell u_l1l2  (.clock(clock), .en(1'b1), .op_a(l1),   .op_b(lc2), .prod(l1l2));
   tlaid_mul_cell u_lc2sq (.clock(clock), .en(1'b1), .op_a(lc2),  .op_b(lc2), .prod(lc2sq));
   tlaid_mul_cell u_lc1sq (.clock(clock), .en(1'b1), .op_a(lc1),  .op_b(lc1), .prod(lc1sq));
   tlaid_mul_cell u_l1sq  (.clock(clock), .en(1'b1), .op_a(l1),   .op_b(l1),  .prod(l1sq));
   tlaid_mul_cell u_gm2   (.clock(clock), .en(1'b1), .op_a(g),    .op_b(m2),  .prod(gm2));
   tlaid_mul_cell u_glc1  (.clock(clock), .en(1'b1), .op_a(g),    .op_b(lc1), .prod(glc1));
   tlaid_mul_cell u_glc2  (.clock(clock), .en(1'b1), .op_a(g),    .op_b(lc2), .prod(glc2));
   tlaid_mul_cell u_l1l2m2 (.clock(clock), .en(1'b1), .op_a(l1l2), .op_b(m2),
                            .prod(l1l2m2));
   tlaid_mul_cell u_m1lc1sq (.clock(clock), .en(1'b1), .op_a(m1), .op_b(lc1sq),
                             .prod(m1lc1sq));
   tlaid_mul_cell u_m2lc2sq (.clock(clock), .en(1'b1), .op_a(m2), .op_b(lc2sq),
                             .prod(m2lc2sq));
   tlaid_mul_cell u_glc1m1 (.clock(clock), .en(1'b1), .op_a(glc1), .op_b(m1),
                            .prod(glc1m1));
   tlaid_mul_cell u_glc2m2 (.clock(clock), .en(1'b1), .op_a(glc2), .op_b(m2),
                            .prod(glc2m2));

   assign d22 = m2lc2sq + i2;

   // sines, stage 0 to 20
   logic signed [31:0] s2, c2, c1, c12;
   logic [15:0]        a_sh, a_el;
   assign a_sh = req_d_ff[0].shoulder_angle;
   assign a_el = req_d_ff[0].elbow_angle;

   tlaid_sin_unit u_s2  (.clock(clock), .en(adv), .angle(a_el), .sine(s2));
   tlaid_sin_unit u_c2  (.clock(clock), .en(adv), .angle(a_el + tlaid_pkg::QUARTER_TURN),
                         .sine(c2));
   tlaid_sin_unit u_c1  (.clock(clock), .en(adv), .angle(a_sh + tlaid_pkg::QUARTER_TURN),
                         .sine(c1));
   tlaid_sin_unit u_c12 (.clock(clock), .en(adv),
                         .angle(a_sh + a_el + tlaid_pkg::QUARTER_TURN), .sine(c12));

   word_type s2_w, c2_w, c1_w, c12_w;
   assign s2_w  = word_type'(s2);
   assign c2_w  = word_type'(c2);
   assign c1_w  = word_type'(c1);
   assign c12_w = word_type'(c12);

   // trig products, stage 20 to 25
   word_type hs, l1l2c, lc2c12, l1c1, gb, gc;
   tlaid_mul_cell #(.SH(30)) u_hs   (.clock(clock), .en(adv), .op_a(l1l2m2), .op_b(s2_w),
                                     .prod(hs));
   tlaid_mul_cell #(.SH(30)) u_l1l2c (.clock(clock), .en(adv), .op_a(l1l2), .op_b(c2_w),
                                      .prod(l1l2c));
   tlaid_mul_cell #(.SH(30)) u_lc2c12 (.clock(clock), .en(adv), .op_a(lc2), .op_b(c12_w),
                                       .prod(lc2c12));
   tlaid_mul_cell #(.SH(30)) u_l1c1 (.clock(clock), .en(adv), .op_a(l1), .op_b(c1_w),
                                     .prod(l1c1));
   tlaid_mul_cell #(.SH(30)) u_gb   (.clock(clock), .en(adv), .op_a(glc1m1), .op_b(c1_w),
                                     .prod(gb));
   tlaid_mul_cell #(.SH(30)) u_gc   (.clock(clock), .en(adv), .op_a(glc2m2), .op_b(c12_w),
                                     .prod(gc));

   // stage 26
   word_type u12_ff, u11_ff, ug_ff;
   word_type hs_ff [26:32];
   word_type gb_ff [26:37];
   word_type gc_ff [26:37];

   // stage 26 to 31
   word_type pm2u12, pm2u11, pgu, w1_26, w2_26, pw22_c, pw12_c, pw11_c;
   assign w1_26 = tlaid_pkg::q12_to_q24(req_d_ff[26].shoulder_velocity);
   assign w2_26 = tlaid_pkg::q12_to_q24(req_d_ff[26].elbow_velocity);

   tlaid_mul_cell u_m2u12 (.clock(clock), .en(adv), .op_a(m2),  .op_b(u12_ff), .prod(pm2u12));
   tlaid_mul_cell u_m2u11 (.clock(clock), .en(adv), .op_a(m2),  .op_b(u11_ff), .prod(pm2u11));
   tlaid_mul_cell u_gu    (.clock(clock), .en(adv), .op_a(gm2), .op_b(ug_ff),  .prod(pgu));
   tlaid_mul_cell u_w22   (.clock(clock), .en(adv), .op_a(w2_26), .op_b(w2_26), .prod(pw22_c));
   tlaid_mul_cell u_w12   (.clock(clock), .en(adv), .op_a(w1_26), .op_b(w2_26), .prod(pw12_c));
   tlaid_mul_cell u_w11   (.clock(clock), .en(adv), .op_a(w1_26), .op_b(w1_26), .prod(pw11_c));

   // stage 32
   word_type d12_ff, d11_ff, w22_ff, w12_ff, w11_ff;
   word_type ga_ff [32:37];

   // stage 32 to 37
   word_type a1_32, a2_32;
   word_type p_w22, p_w12, p_a2d12, p_a1d11, p_w11, p_a2d22, p_a1d12;
   assign a1_32 = tlaid_pkg::q12_to_q24(req_d_ff[32].shoulder_accel);
   assign a2_32 = tlaid_pkg::q12_to_q24(req_d_ff[32].elbow_accel);

   tlaid_mul_cell u_pw22  (.clock(clock), .en(adv), .op_a(hs_ff[32]), .op_b(w22_ff),
                           .prod(p_w22));
   tlaid_mul_cell u_pw12  (.clock(clock), .en(adv), .op_a(hs_ff[32]), .op_b(w12_ff),
                           .prod(p_w12));
   tlaid_mul_cell u_pw11  (.clock(clock), .en(adv), .op_a(hs_ff[32]), .op_b(w11_ff),
                           .prod(p_w11));
   tlaid_mul_cell u_a2d12 (.clock(clock), .en(adv), .op_a(a2_32), .op_b(d12_ff),
                           .prod(p_a2d12));
   tlaid_mul_cell u_a1d11 (.clock(clock), .en(adv), .op_a(a1_32), .op_b(d11_ff),
                           .prod(p_a1d11));
   tlaid_mul_cell u_a2d22 (.clock(clock), .en(adv), .op_a(a2_32), .op_b(d22),
                           .prod(p_a2d22));
   tlaid_mul_cell u_a1d12 (.clock(clock), .en(adv), .op_a(a1_32), .op_b(d12_ff),
                           .prod(p_a1d12));

   // stages 38 to 40
   word_type t1a_ff, t1b_ff, t2a_ff, t2b_ff, t1_ff, t2_ff;
   logic [62:0] mag1_ff, mag2_ff;
   logic        neg1_ff, neg2_ff;
   logic [62:0] mag1_in, mag2_in;
   assign mag1_in = t1_ff[63] ? 63'(-t1_ff) : t1_ff[62:0];
   assign mag2_in = t2_ff[63] ? 63'(-t2_ff) : t2_ff[62:0];

   // round half away from zero, then clip to 32 bits
   logic [55:0] rm1, rm2;
   logic        clip1, clip2;
   assign rm1   = 56'(({1'b0, mag1_ff} + 64'd128) >> 8);
   assign rm2   = 56'(({1'b0, mag2_ff} + 64'd128) >> 8);
   assign clip1 = neg1_ff ? (rm1 > 56'h8000_0000) : (rm1 > 56'h7FFF_FFFF);
   assign clip2 = neg2_ff ? (rm2 > 56'h8000_0000) : (rm2 > 56'h7FFF_FFFF);

   always_comb begin
      rsp_in.shoulder_torque = clip1 ? (neg1_ff ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
                             : (neg1_ff ? -$signed(rm1[31:0]) : $signed(rm1[31:0]));
      rsp_in.elbow_torque    = clip2 ? (neg2_ff ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
                             : (neg2_ff ? -$signed(rm2[31:0]) : $signed(rm2[31:0]));
      rsp_in.saturated       = clip1 | clip2;
   end

   assign adv       = !(v_ff[LAST] && rsp_valid_ff && !rsp_ready);
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= tlaid_pkg::CSR_RESET;
      end else if (csr_wr_en) begin
         csr_ff[csr_index] <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[LAST-1:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         req_d_ff[0] <= req_data;
         for (int i = 1; i <= 32; i++) req_d_ff[i] <= req_d_ff[i-1];
         u12_ff    <= lc2sq + l1l2c;
         u11_ff    <= l1sq + (l1l2c <<< 1) + lc2sq;
         ug_ff     <= lc2c12 + l1c1;
         hs_ff[26] <= hs;
         gb_ff[26] <= gb;
         gc_ff[26] <= gc;
         for (int i = 27; i <= 32; i++) hs_ff[i] <= hs_ff[i-1];
         for (int i = 27; i <= 37; i++) begin
            gb_ff[i] <= gb_ff[i-1];
            gc_ff[i] <= gc_ff[i-1];
         end
         d12_ff    <= i2 + pm2u12;
         d11_ff    <= m1lc1sq + i1 + i2 + pm2u11;
         w22_ff    <= pw22_c;
         w12_ff    <= pw12_c;
         w11_ff    <= pw11_c;
         ga_ff[32] <= pgu;
         for (int i = 33; i <= 37; i++) ga_ff[i] <= ga_ff[i-1];
         t1a_ff    <= p_a2d12 - p_w22 - (p_w12 <<< 1);
         t1b_ff    <= p_a1d11 + ga_ff[37] + gb_ff[37];
         t2a_ff    <= p_w11 + p_a2d22;
         t2b_ff    <= p_a1d12 + gc_ff[37];
         t1_ff     <= t1a_ff + t1b_ff;
         t2_ff     <= t2a_ff + t2b_ff;
         mag1_ff   <= mag1_in;
         mag2_ff   <= mag2_in;
         neg1_ff   <= t1_ff[63];
         neg2_ff   <= t2_ff[63];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv && v_ff[LAST]) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && v_ff[LAST]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.saturated) |->
         (rsp_ff.shoulder_torque == 32'sh7FFF_FFFF ||
          rsp_ff.shoulder_torque == 32'sh8000_0000 ||
          rsp_ff.elbow_torque == 32'sh7FFF_FFFF ||
          rsp_ff.elbow_torque == 32'sh8000_0000))
      else $error("saturated flag without clipped torque");

   a_stall_holds_item: assert property (@(posedge clock) disable iff (reset)
      (v_ff[LAST] && rsp_valid_ff && !rsp_ready) |=> v_ff[LAST])
      else $error("last stage item lost during stall");

   a_rsp_from_valid: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(v_ff[LAST]))
      else $error("result produced without a valid item");
`endif

endmodule

>>> sim/tb_two_link_arm_inverse_dynamics_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_two_link_arm_inverse_dynamics_core
// Drives joint-state items through the inverse dynamics core under several
// link constant settings and idling patterns, and compares every torque item
// with a bit-exact fixed-point model of the arm kept in a scoreboard.
// ----------------------------------------------------------------------------

class torque_board;
   logic [31:0]        link_const [tlaid_pkg::NUM_CSR];
   tlaid_pkg::rsp_type expected_torques [$];
   int                 mismatches;

   function new();
      for (int i = 0; i < tlaid_pkg::NUM_CSR; i++) link_const[i] = tlaid_pkg::CSR_RESET[i];
      mismatches = 0;
   endfunction

   function void set_const(tlaid_pkg::csr_index_type idx, logic [31:0] val);
      link_const[idx] = val;
   endfunction

   // magnitude product, shifted, capped at 2^59, sign restored
   function longint fix_mul(longint a, longint b, int sh);
      bit              neg;
      bit [63:0]       ma, mb;
      bit [127:0]      prod;
      longint          res;
      neg  = (a < 0) != (b < 0);
      ma   = a < 0 ? -a : a;
      mb   = b < 0 ? -b : b;
      prod = ({64'b0, ma} * {64'b0, mb}) >> sh;
      if (prod > 128'(tlaid_pkg::SAT_LIM)) prod = 128'(tlaid_pkg::SAT_LIM);
      res  = longint'(prod[63:0]);
      return neg ? -res : res;
   endfunction

   function longint fm(longint a, longint b);
      return fix_mul(a, b, 24);
   endfunction

   function longint tm(longint a, longint b);
      return fix_mul(a, b, 30);
   endfunction

   function longint sine_q30(bit [15:0] ang);
      longint unsigned divs [5] = '{110, 72, 42, 20, 6};
      longint unsigned r, x, x2, t, p, s;
      bit [1:0]        quad;
      quad = ang[15:14];
      r    = ang[13:0];
      if (quad[0]) r = 16384 - r;
      x  = (r * 64'(tlaid_pkg::PI_Q30)) >> 15;
      x2 = (x * x) >> 30;
      t  = 64'(tlaid_pkg::ONE_Q30);
      for (int i = 0; i < 5; i++) begin
         p = ((x2 * t) >> 30) / divs[i];
         t = p >= 64'(tlaid_pkg::ONE_Q30) ? 0 : 64'(tlaid_pkg::ONE_Q30) - p;
      end
      s = (x * t) >> 30;
      return quad[1] ? -longint'(s) : longint'(s);
   endfunction

   function longint round_q16(longint t, ref bit clip);
      longint r;
      if (t >= 0) r = (t + 128) / 256;
      else r = -((-t + 128) / 256);
      if (r > 64'sd2147483647) begin
         clip = 1;
         r = 64'sd2147483647;
      end else if (r < -64'sd2147483648) begin
         clip = 1;
         r = -64'sd2147483648;
      end
      return r;
   endfunction

   function tlaid_pkg::rsp_type torque_of(tlaid_pkg::req_type q);
      longint  len1, lc1, lc2, m1, m2, in1, in2, g;
      longint  w1, w2, a1, a2, s2, c2, c1, c12;
      longint  l1l2, hs, l1l2c, lc2sq, d11, d12, d22, t1, t2;
      bit      clip;
      bit [15:0] sum_ang;
      tlaid_pkg::rsp_type o;
      len1 = longint'(link_const[tlaid_pkg::CSR_LINK1_LENGTH]);
      lc1  = longint'(link_const[tlaid_pkg::CSR_LINK1_COM_DIST]);
      lc2  = longint'(link_const[tlaid_pkg::CSR_LINK2_COM_DIST]);
      m1   = longint'(link_const[tlaid_pkg::CSR_LINK1_MASS]);
      m2   = longint'(link_const[tlaid_pkg::CSR_LINK2_MASS]);
      in1  = longint'(link_const[tlaid_pkg::CSR_LINK1_INERTIA]);
      in2  = longint'(link_const[tlaid_pkg::CSR_LINK2_INERTIA]);
      g    = longint'(link_const[tlaid_pkg::CSR_GRAVITY_ACCEL]);
      w1 = longint'(q.shoulder_velocity) * 4096;
      w2 = longint'(q.elbow_velocity) * 4096;
      a1 = longint'(q.shoulder_accel) * 4096;
      a2 = longint'(q.elbow_accel) * 4096;
      sum_ang = q.shoulder_angle + q.elbow_angle;
      s2  = sine_q30(q.elbow_angle);
      c2  = sine_q30(q.elbow_angle + tlaid_pkg::QUARTER_TURN);
      c1  = sine_q30(q.shoulder_angle + tlaid_pkg::QUARTER_TURN);
      c12 = sine_q30(sum_ang + tlaid_pkg::QUARTER_TURN);
      l1l2  = fm(len1, lc2);
      hs    = tm(fm(l1l2, m2), s2);
      l1l2c = tm(l1l2, c2);
      lc2sq = fm(lc2, lc2);
      d12 = in2 + fm(m2, lc2sq + l1l2c);
      d11 = fm(m1, fm(lc1, lc1)) + in1 + in2 + fm(m2, fm(len1, len1) + 2 * l1l2c + lc2sq);
      d22 = fm(m2, lc2sq) + in2;
      t1 = -fm(hs, fm(w2, w2)) - 2 * fm(hs, fm(w1, w2)) + fm(a2, d12) + fm(a1, d11)
           + fm(fm(g, m2), tm(lc2, c12) + tm(len1, c1)) + tm(fm(fm(g, lc1), m1), c1);
      t2 = fm(hs, fm(w1, w1)) + fm(a2, d22) + fm(a1, d12) + tm(fm(fm(g, lc2), m2), c12);
      clip = 0;
      o.shoulder_torque = 32'(round_q16(t1, clip));
      o.elbow_torque    = 32'(round_q16(t2, clip));
      o.saturated       = clip;
      return o;
   endfunction

   function void note_item(tlaid_pkg::req_type q);
      expected_torques.push_back(torque_of(q));
   endfunction

   function void check_result(tlaid_pkg::rsp_type got);
      tlaid_pkg::rsp_type want;
      if (expected_torques.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected result item %h", got);
         return;
      end
      want = expected_torques.pop_front();
      if (got.shoulder_torque !== want.shoulder_torque || got.elbow_torque !== want.elbow_torque
          || got.saturated !== want.saturated) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: exp t1=%h t2=%h sat=%b got t1=%h t2=%h sat=%b",
                     want.shoulder_torque, want.elbow_torque, want.saturated,
                     got.shoulder_torque, got.elbow_torque, got.saturated);
      end
   endfunction

   function int pending();
      return expected_torques.size();
   endfunction
endclass

module tb_two_link_arm_inverse_dynamics_core;
   localparam int CYCLE_LIMIT = 300000;

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_ready;
   tlaid_pkg::req_type req_data = '0;
   logic               rsp_valid;
   logic               rsp_ready = 0;
   tlaid_pkg::rsp_type rsp_data;
   logic               csr_wr_en = 0;
   logic [2:0]         csr_index = '0;
   logic [31:0]        csr_wr_data = '0;

   torque_board board = new();
   bit          tx_idle = 0;
   bit          rx_stall = 0;
   bit          hold_req = 0;
   int          idle_pct = 71;

   two_link_arm_inverse_dynamics_core u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data)
   );

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) board.note_item(req_data);
         if (rsp_valid && rsp_ready) board.check_result(rsp_data);
      end
   end

   // receiver: random stalls, plus a long hold-off on request
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req = 0;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 0;
         end else if (rx_stall) begin
            rsp_ready <= ($urandom_range(99) >= idle_pct);
         end else begin
            rsp_ready <= 1;
         end
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("[FAIL] regression broken");
      $finish;
   end

   // called at a falling edge, returns at a falling edge
   task automatic send_item(tlaid_pkg::req_type q);
      if (tx_idle && $urandom_range(99) < idle_pct) begin
         req_valid <= 0;
         do @(negedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_valid <= 1;
      req_data  <= q;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic write_const(tlaid_pkg::csr_index_type idx, logic [31:0] val);
      csr_wr_en   <= 1;
      csr_index   <= idx;
      csr_wr_data <= val;
      board.set_const(idx, val);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (board.pending() != 0) @(negedge clock);
      repeat (45) @(negedge clock);
   endtask

   function automatic logic [23:0] small_rate();
      return 24'($signed($urandom_range(65536)) - 32768);
   endfunction

   function automatic tlaid_pkg::req_type rand_item();
      tlaid_pkg::req_type q;
      int      kind;
      kind = $urandom_range(9);
      q = {$urandom, $urandom, $urandom, $urandom};
      if (kind >= 6 && kind <= 8) begin
         q.shoulder_velocity = small_rate();
         q.elbow_velocity    = small_rate();
         q.shoulder_accel    = small_rate();
         q.elbow_accel       = small_rate();
      end else if (kind == 9) begin
         q.shoulder_velocity = $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
         q.elbow_velocity    = $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
         q.shoulder_accel    = $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
         q.elbow_accel       = $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
      end
      return q;
   endfunction

   task automatic run_random(int n, bit idle_tx, bit idle_rx, bit long_hold);
      tx_idle  = idle_tx;
      rx_stall = idle_rx;
      for (int i = 0; i < n; i++) begin
         if (long_hold && i == 40) hold_req = 1;
         send_item(rand_item());
      end
   endtask

   task automatic directed_items();
      logic [15:0] angs [6] = '{16'h0000, 16'h4000, 16'h8000, 16'h7FFF, 16'hC000, 16'hFFFF};
      tlaid_pkg::req_type q;
      for (int i = 0; i < 6; i++) begin
         q = '0;
         q.shoulder_angle = angs[i];
         q.elbow_angle    = angs[5 - i];
         send_item(q);
      end
      q = '{16'h7FFF, 16'h7FFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF};
      send_item(q);
      q = '{16'h8000, 16'h8000, 24'h800000, 24'h800000, 24'h800000, 24'h800000};
      send_item(q);
      q = '{16'h4000, 16'hC000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h800000};
      send_item(q);
      q = '{16'h2000, 16'h1000, 24'h001000, 24'hFFF000, 24'h002000, 24'hFFE000};
      send_item(q);
      q = '{16'hFFFF, 16'h0001, 24'h000001, 24'hFFFFFF, 24'h000000, 24'h000001};
      send_item(q);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      tx_idle = 0;
      rx_stall = 0;
      directed_items();
      run_random(280, 0, 0, 0);
      drain();

      for (int i = 0; i < tlaid_pkg::NUM_CSR; i++)
         write_const(tlaid_pkg::csr_index_type'(i), 32'h0);
      csr_wr_en <= 0;
      repeat (12) @(negedge clock);
      directed_items();
      run_random(150, 1, 0, 0);
      drain();

      for (int i = 0; i < tlaid_pkg::NUM_CSR; i++)
         write_const(tlaid_pkg::csr_index_type'(i), 32'hFFFF_FFFF);
      csr_wr_en <= 0;
      repeat (12) @(negedge clock);
      directed_items();
      run_random(150, 0, 1, 0);
      drain();

      for (int i = 0; i < tlaid_pkg::NUM_CSR; i++)
         write_const(tlaid_pkg::csr_index_type'(i), $urandom);
      csr_wr_en <= 0;
      repeat (12) @(negedge clock);
      run_random(300, 1, 1, 0);
      drain();

      for (int i = 0; i < tlaid_pkg::NUM_CSR; i++)
         write_const(tlaid_pkg::csr_index_type'(i),
                     $urandom_range(tlaid_pkg::CSR_RESET[i] * 2 + 16));
      csr_wr_en <= 0;
      repeat (12) @(negedge clock);
      run_random(450, 0, 0, 1);
      drain();

      for (int i = 0; i < tlaid_pkg::NUM_CSR; i++)
         write_const(tlaid_pkg::csr_index_type'(i), tlaid_pkg::CSR_RESET[i]);
      csr_wr_en <= 0;
      repeat (12) @(negedge clock);
      idle_pct = 31;
      run_random(350, 1, 1, 0);
      drain();

      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
